[design/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers for the stream find and replace core.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int REPLACE_MAX = 32;
    localparam int LEN_W       = 6;
    localparam int SLOT_W      = 5;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] SPACE_BYTE   = 8'h20;

    // input commands
    localparam logic [1:0] CMD_PATTERN = 2'd0;
    localparam logic [1:0] CMD_REPLACE = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;
    localparam logic [1:0] CMD_END     = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_PASS    = 2'd0;
    localparam logic [1:0] KIND_REPL    = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // register indexes
    localparam logic [2:0] REG_CASE_SENS  = 3'd0;
    localparam logic [2:0] REG_REPLACE    = 3'd1;
    localparam logic [2:0] REG_PLEN       = 3'd2;
    localparam logic [2:0] REG_RLEN       = 3'd3;
    localparam logic [2:0] REG_START      = 3'd4;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        in_byte;
    } sfr_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] match_offset;
        logic [31:0] match_count;
        logic        found_any;
        logic        last;
    } sfr_out_t;

    typedef struct packed {
        logic load_pat;
        logic write;
        logic shift;
        logic fold_en;
    } sfr_cell_ctrl_t;

    // ascii lower-case fold, when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        if (en && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

[design/sfr_cell.sv]
// ----------------------------------------------------------------------------
// sfr_cell
// One window position: holds a pattern byte and a text byte and compares them.
// ----------------------------------------------------------------------------
module sfr_cell import sfr_pkg::*; (
    input  logic           aclk,
    input  sfr_cell_ctrl_t ctrl,
    input  logic           pat_sel,
    input  logic           wr_sel,
    input  logic           active,
    input  logic [7:0]     in_byte,
    input  logic [7:0]     right_byte,
    output logic [7:0]     byte_q,
    output logic           ok
);

    logic [7:0] pat_reg;
    logic [7:0] byte_reg;
    logic [7:0] txt_cmp;

    // pattern load, text write or shift from the neighbour
    always_ff @(posedge aclk) begin
        if (ctrl.load_pat && pat_sel) begin
            pat_reg <= in_byte;
        end
        if (ctrl.write && wr_sel) begin
            byte_reg <= in_byte;
        end else if (ctrl.shift) begin
            byte_reg <= right_byte;
        end
    end

    // newline compares as space
    assign txt_cmp = (byte_reg == NEWLINE_BYTE) ? SPACE_BYTE : byte_reg;
    assign ok      = !active ||
                     (fold_byte(pat_reg, ctrl.fold_en) == fold_byte(txt_cmp, ctrl.fold_en));
    assign byte_q  = byte_reg;

endmodule

[design/stream_find_replace_core.sv]
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Streaming find and replace over a byte stream through a row of window cells.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | beat
// s_      | in  | s_valid / s_ready  | sfr_in_t command beat
// m_      | out | m_valid / m_ready  | sfr_out_t result beat
// cfg_    | in  | cfg_valid/cfg_ready| register index and data
//
// A load beat, and a text beat before the start offset, finish in the idle
// state; any other text beat is written, then compared across all cells, and
// then followed by its replacement bytes or its match report. End of text
// goes to the summary, in replace mode after flushing the held window bytes.
// Reset is synchronous, active low; it clears control state and counters.
// A stalled m_ready holds the sequencer and the input stays not ready.
// ----------------------------------------------------------------------------
module stream_find_replace_core import sfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sfr_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output sfr_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = $clog2(REPLACE_MAX);

    typedef enum logic [2:0] {
        ST_IDLE, ST_EVAL, ST_REPORT, ST_REPL, ST_FLUSH, ST_SUMMARY
    } state_t;

    state_t      state_reg;
    logic        case_reg, repl_mode_reg;
    logic [LEN_W-1:0] plen_reg, rlen_reg;
    logic [31:0] start_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [31:0] toff_reg, t_reg, count_reg;
    logic [LEN_W-1:0] ridx_reg;
    logic [7:0]  rep_mem [REPLACE_MAX];
    logic        m_valid_reg;
    sfr_out_t    m_data_reg;

    logic [LEN_W-1:0] plen_eff, rlen_eff;
    logic        out_ok, s_fire, cfg_fire, all_ok, do_cmp, cmp_match, first;
    logic [31:0] count_inc;
    sfr_cell_ctrl_t ctrl;
    logic [7:0]  cell_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_ok;

    // effective lengths
    always_comb begin
        if (plen_reg == '0) begin
            plen_eff = LEN_W'(1);
        end else if (plen_reg > LEN_W'(PATTERN_MAX)) begin
            plen_eff = LEN_W'(PATTERN_MAX);
        end else begin
            plen_eff = plen_reg;
        end
        rlen_eff = (rlen_reg > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rlen_reg;
    end

    assign out_ok    = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_ok;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign all_ok    = &cell_ok;
    assign do_cmp    = (fill_reg == plen_eff);
    assign cmp_match = do_cmp && all_ok;
    assign first     = (count_reg == '0);
    assign count_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;

    // cell control
    always_comb begin
        ctrl.load_pat = s_fire && (s_data.cmd == CMD_PATTERN);
        ctrl.write    = s_fire && (s_data.cmd == CMD_TEXT) && !(toff_reg < start_reg);
        ctrl.shift    = ((state_reg == ST_EVAL) && out_ok && do_cmp && !all_ok) ||
                        ((state_reg == ST_FLUSH) && out_ok && (fill_reg != '0));
        ctrl.fold_en  = !case_reg;
    end

    // window cells
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic [7:0] right;
        if (i == PATTERN_MAX - 1) begin : g_end
            assign right = '0;
        end else begin : g_mid
            assign right = cell_byte[i+1];
        end
        sfr_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pat_sel    (s_data.slot == SLOT_W'(i)),
            .wr_sel     (fill_reg == LEN_W'(i)),
            .active     (LEN_W'(i) < plen_eff),
            .in_byte    (s_data.in_byte),
            .right_byte (right),
            .byte_q     (cell_byte[i]),
            .ok         (cell_ok[i])
        );
    end

    // replacement store
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.cmd == CMD_REPLACE) begin
            rep_mem[s_data.slot[IDX_W-1:0]] <= s_data.in_byte;
        end
    end

    // text byte of the beat under evaluation: the newest window cell
    function automatic logic [7:0] t_byte_hold();
        logic [7:0] b;
        b = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (LEN_W'(k + 1) == fill_reg) begin
                b = cell_byte[k];
            end
        end
        return b;
    endfunction

    // sequencer, counters, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            case_reg      <= 1'b1;
            repl_mode_reg <= 1'b0;
            plen_reg      <= LEN_W'(1);
            rlen_reg      <= '0;
            start_reg     <= '0;
            fill_reg      <= '0;
            toff_reg      <= '0;
            count_reg     <= '0;
            ridx_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_fire) begin
                unique case (cfg_index)
                    REG_CASE_SENS: case_reg <= cfg_data[0];
                    REG_REPLACE: begin
                        repl_mode_reg <= cfg_data[0];
                        fill_reg      <= '0;
                    end
                    REG_PLEN: begin
                        plen_reg <= cfg_data[LEN_W-1:0];
                        fill_reg <= '0;
                    end
                    REG_RLEN:  rlen_reg <= cfg_data[LEN_W-1:0];
                    REG_START: begin
                        start_reg <= cfg_data;
                        fill_reg  <= '0;
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        unique case (s_data.cmd)
                            CMD_TEXT: begin
                                t_reg <= toff_reg;
                                if (toff_reg != 32'hFFFF_FFFF) begin
                                    toff_reg <= toff_reg + 32'd1;
                                end
                                if (toff_reg < start_reg) begin
                                    m_valid_reg <= 1'b1;
                                    m_data_reg  <= '{KIND_PASS, s_data.in_byte, 32'd0,
                                                     count_reg, !first, 1'b1};
                                end else begin
                                    fill_reg  <= fill_reg + LEN_W'(1);
                                    state_reg <= ST_EVAL;
                                end
                            end
                            CMD_END: state_reg <= repl_mode_reg ? ST_FLUSH : ST_SUMMARY;
                            default: ;
                        endcase
                    end
                end
                ST_EVAL: begin
                    if (out_ok) begin
                        state_reg <= ST_IDLE;
                        if (!repl_mode_reg) begin
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '{KIND_PASS, t_byte_hold(), 32'd0,
                                             count_reg, !first, !(cmp_match && first)};
                            if (cmp_match && first) begin
                                state_reg <= ST_REPORT;
                            end
                        end else if (do_cmp && !all_ok) begin
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '{KIND_PASS, cell_byte[0], 32'd0,
                                             count_reg, !first, 1'b1};
                        end
                        if (cmp_match) begin
                            count_reg <= count_inc;
                            fill_reg  <= '0;
                            if (repl_mode_reg && rlen_eff != '0) begin
                                ridx_reg  <= '0;
                                state_reg <= ST_REPL;
                            end
                        end else if (do_cmp) begin
                            fill_reg <= plen_eff - LEN_W'(1);
                        end
                    end
                end
                ST_REPORT: begin
                    if (out_ok) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{KIND_REPORT, 8'd0,
                                         t_reg - 32'(plen_eff - LEN_W'(1)),
                                         count_reg, !first, 1'b1};
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_REPL: begin
                    if (out_ok) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{KIND_REPL, rep_mem[ridx_reg[IDX_W-1:0]], 32'd0,
                                         count_reg, !first,
                                         (ridx_reg + LEN_W'(1)) == rlen_eff};
                        ridx_reg    <= ridx_reg + LEN_W'(1);
                        if ((ridx_reg + LEN_W'(1)) == rlen_eff) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (fill_reg == '0) begin
                        state_reg <= ST_SUMMARY;
                    end else if (out_ok) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{KIND_PASS, cell_byte[0], 32'd0,
                                         count_reg, !first, 1'b0};
                        fill_reg    <= fill_reg - LEN_W'(1);
                    end
                end
                ST_SUMMARY: begin
                    if (out_ok) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{KIND_SUMMARY, 8'd0, 32'd0,
                                         count_reg, !first, 1'b1};
                        fill_reg    <= '0;
                        toff_reg    <= '0;
                        count_reg   <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // window never holds more than the pattern
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= plen_eff) else $error("window fill beyond pattern length");

    // input only taken while the sequencer is idle
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("input ready while busy");

    // summary always closes its beat
    a_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_SUMMARY) |-> m_data.last)
        else $error("summary without last");

endmodule

[tb/stream_find_replace_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_core_tb
// Drives command beats and register writes into the find and replace core,
// predicts every result beat with an in-bench copy of the matcher, and checks
// the result stream in order under random idling on both channels.
// ----------------------------------------------------------------------------
module stream_find_replace_core_tb;
    import sfr_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] data;
        sfr_in_t     item;
        bit          typed;
        sfr_out_t    res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    sfr_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    sfr_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // shadow registers and state of the matcher
    logic        sh_case;
    logic        sh_repl;
    logic [5:0]  sh_plen;
    logic [5:0]  sh_rlen;
    logic [31:0] sh_start;
    logic [7:0]  pat_mem [PATTERN_MAX];
    logic [7:0]  rep_mem [REPLACE_MAX];
    logic [7:0]  win_mem [PATTERN_MAX];
    int          win_fill;
    logic [31:0] text_pos;
    logic [31:0] hits;

    sfr_out_t    pending_results[$];
    stim_row_t   directed_rows[$];
    int          s_idle_pct = 0;
    int          m_idle_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          beats_sent = 0;
    int          cycles = 0;

    stream_find_replace_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stream_find_replace_core: mismatch");
            $finish;
        end
    end

    function automatic int eff_plen();
        if (sh_plen == 0) return 1;
        if (sh_plen > PATTERN_MAX) return PATTERN_MAX;
        return int'(sh_plen);
    endfunction

    function automatic int eff_rlen();
        return (sh_rlen > REPLACE_MAX) ? REPLACE_MAX : int'(sh_rlen);
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        if (!sh_case && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
        return c;
    endfunction

    function automatic void clear_win();
        for (int i = 0; i < PATTERN_MAX; i++) win_mem[i] = '0;
        win_fill = 0;
    endfunction

    function automatic void push_result(input logic [1:0] k, input logic [7:0] b,
                                        input logic [31:0] off, inout int n);
        sfr_out_t r;
        if (n >= 32) return;
        r.kind = k;
        r.out_byte = b;
        r.match_offset = off;
        r.match_count = hits;
        r.found_any = (hits != 0);
        r.last = 1'b0;
        pending_results.push_back(r);
        n++;
    endfunction

    // expected results of one accepted command beat
    function automatic void predict_results(input sfr_in_t it);
        int n;
        int p;
        logic [31:0] t;
        logic [7:0] tb;
        bit hit;
        bit first;
        n = 0;
        case (it.cmd)
            CMD_PATTERN: pat_mem[it.slot] = it.in_byte;
            CMD_REPLACE: rep_mem[it.slot] = it.in_byte;
            CMD_TEXT: begin
                t = text_pos;
                if (text_pos != 32'hFFFF_FFFF) text_pos++;
                if (t < sh_start) begin
                    push_result(KIND_PASS, it.in_byte, '0, n);
                end else begin
                    p = eff_plen();
                    if (!sh_repl) push_result(KIND_PASS, it.in_byte, '0, n);
                    if (win_fill < p) win_mem[win_fill++] = it.in_byte;
                    if (win_fill >= p) begin
                        hit = 1;
                        for (int i = 0; i < p; i++) begin
                            tb = (win_mem[i] == NEWLINE_BYTE) ? SPACE_BYTE : win_mem[i];
                            if (lower(pat_mem[i]) != lower(tb)) hit = 0;
                        end
                        if (hit) begin
                            first = (hits == 0);
                            if (hits != 32'hFFFF_FFFF) hits++;
                            if (sh_repl) begin
                                for (int i = 0; i < eff_rlen(); i++)
                                    push_result(KIND_REPL, rep_mem[i], '0, n);
                            end else if (first) begin
                                push_result(KIND_REPORT, '0, t - 32'(p - 1), n);
                            end
                            clear_win();
                        end else begin
                            if (sh_repl) push_result(KIND_PASS, win_mem[0], '0, n);
                            for (int i = 0; i < p - 1; i++) win_mem[i] = win_mem[i + 1];
                            win_mem[p - 1] = '0;
                            win_fill = p - 1;
                        end
                    end
                end
            end
            default: begin
                if (sh_repl)
                    for (int i = 0; i < win_fill; i++)
                        push_result(KIND_PASS, win_mem[i], '0, n);
                push_result(KIND_SUMMARY, '0, '0, n);
                clear_win();
                text_pos = '0;
                hits = '0;
            end
        endcase
        if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // wait until every expected beat has come and the core has settled
    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        s_valid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CASE_SENS: sh_case = data[0];
            REG_REPLACE:   begin sh_repl = data[0]; clear_win(); end
            REG_PLEN:      begin sh_plen = data[5:0]; clear_win(); end
            REG_RLEN:      sh_rlen = data[5:0];
            REG_START:     begin sh_start = data; clear_win(); end
            default: ;
        endcase
    endtask

    // offer one command beat; a typed result replaces the prediction
    task automatic send_beat(input sfr_in_t it, input bit typed, input sfr_out_t res);
        int sz;
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sz = pending_results.size();
        predict_results(it);
        if (typed) begin
            while (pending_results.size() > sz) void'(pending_results.pop_back());
            pending_results.push_back(res);
        end
        beats_sent++;
    endtask

    task automatic send_cmd(input logic [1:0] c, input logic [4:0] sl, input logic [7:0] b);
        sfr_in_t it;
        it.cmd = c;
        it.slot = sl;
        it.in_byte = b;
        send_beat(it, 1'b0, '0);
    endtask

    // result channel: compare each beat with the oldest expectation
    always @(posedge aclk) begin
        sfr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.kind !== want.kind || m_data.out_byte !== want.out_byte ||
                    m_data.match_offset !== want.match_offset ||
                    m_data.match_count !== want.match_count ||
                    m_data.found_any !== want.found_any || m_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat: expected %p, got %p", want, m_data);
                end
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    function automatic stim_row_t row_cmd(input logic [1:0] c, input logic [4:0] sl,
                                          input logic [7:0] b);
        stim_row_t r;
        r = '{default: '0};
        r.item.cmd = c;
        r.item.slot = sl;
        r.item.in_byte = b;
        return r;
    endfunction

    function automatic stim_row_t row_reg(input logic [2:0] idx, input logic [31:0] d);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = d;
        return r;
    endfunction

    function automatic stim_row_t row_typed(input logic [1:0] c, input logic [7:0] b,
                                            input sfr_out_t res);
        stim_row_t r;
        r = row_cmd(c, '0, b);
        r.typed = 1'b1;
        r.res = res;
        return r;
    endfunction

    // random register settings, mostly short patterns
    task automatic random_settings();
        int r;
        logic [31:0] v;
        if ($urandom_range(1)) write_reg(REG_CASE_SENS, {$urandom} & ~32'h1 | $urandom_range(1));
        if ($urandom_range(1)) write_reg(REG_REPLACE, {$urandom} & ~32'h1 | $urandom_range(1));
        if ($urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 3) write_reg(REG_PLEN, 32'd0);
            else if (r < 6) write_reg(REG_PLEN, 32'd32);
            else if (r < 8) write_reg(REG_PLEN, 32'd63);
            else write_reg(REG_PLEN, $urandom_range(1, 4));
        end
        if ($urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 10) write_reg(REG_RLEN, 32'd32);
            else if (r < 15) write_reg(REG_RLEN, $urandom_range(33, 63));
            else write_reg(REG_RLEN, $urandom_range(0, 4));
        end
        if ($urandom_range(3) == 0) begin
            r = $urandom_range(99);
            if (r < 5) v = 32'hFFFF_FFFF;
            else if (r < 10) v = $urandom;
            else if (r < 50) v = $urandom_range(1, 8);
            else v = 0;
            write_reg(REG_START, v);
        end
    endtask

    // a text that carries copies of the pattern, then usually end of text
    task automatic random_text();
        int len;
        int p;
        logic [7:0] b;
        p = eff_plen();
        if ($urandom_range(3) == 0)
            for (int i = 0; i < p; i++)
                send_cmd(CMD_PATTERN, i[4:0], $urandom_range(2) == 0 ? 8'h20 :
                         ($urandom_range(1) ? 8'h41 + $urandom_range(3) :
                          8'h61 + $urandom_range(3)));
        if ($urandom_range(5) == 0)
            send_cmd(CMD_REPLACE, $urandom_range(31), $urandom_range(255));
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 35) begin
                for (int i = 0; i < p; i++) begin
                    b = pat_mem[i];
                    if (b == SPACE_BYTE && $urandom_range(1)) b = NEWLINE_BYTE;
                    else if (!sh_case && $urandom_range(1) &&
                             ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)))
                        b = b ^ 8'h20;
                    send_cmd(CMD_TEXT, $urandom_range(31), b);
                end
            end else begin
                b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                    pat_mem[$urandom_range(p - 1)];
                send_cmd(CMD_TEXT, $urandom_range(31), b);
            end
        end
        if ($urandom_range(99) < 85) send_cmd(CMD_END, $urandom_range(31), $urandom_range(255));
    endtask

    // one idling phase of random sessions and noise
    task automatic random_phase(input int budget, input bit squeeze);
        int stop_at;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at) begin
            random_settings();
            if (squeeze) begin
                // long receiver hold while text keeps coming, then a full drain
                hold_req = 400;
                write_reg(REG_REPLACE, 32'd1);
                write_reg(REG_RLEN, 32'd32);
                write_reg(REG_PLEN, 32'd1);
                write_reg(REG_START, 32'd0);
                for (int i = 0; i < 30; i++) send_cmd(CMD_TEXT, '0, pat_mem[0]);
                send_cmd(CMD_END, '0, '0);
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
                squeeze = 0;
            end
            if ($urandom_range(99) < 85) begin
                random_text();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_cmd($urandom_range(3), $urandom_range(31), $urandom_range(255));
            end
        end
    endtask

    initial begin
        sfr_out_t r;
        sh_case = 1'b1;
        sh_repl = 1'b0;
        sh_plen = 6'd1;
        sh_rlen = 6'd0;
        sh_start = '0;
        text_pos = '0;
        hits = '0;
        clear_win();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every store entry written before any text reads it
        for (int i = 0; i < PATTERN_MAX; i++) send_cmd(CMD_PATTERN, i[4:0], 8'h41 + 8'(i));
        for (int i = 0; i < REPLACE_MAX; i++) send_cmd(CMD_REPLACE, i[4:0], 8'h30 + 8'(i));

        // directed table
        r = '{kind: KIND_SUMMARY, out_byte: 8'h00, match_offset: 32'd0,
              match_count: 32'd0, found_any: 1'b0, last: 1'b1};
        directed_rows.push_back(row_typed(CMD_END, 8'h00, r));
        r = '{kind: KIND_PASS, out_byte: 8'hFF, match_offset: 32'd0,
              match_count: 32'd0, found_any: 1'b0, last: 1'b1};
        directed_rows.push_back(row_typed(CMD_TEXT, 8'hFF, r));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd31, 8'h41));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, 8'h41));
        directed_rows.push_back(row_cmd(CMD_END, 5'd31, 8'hFF));
        directed_rows.push_back(row_reg(REG_CASE_SENS, 32'd0));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, 8'h61));
        directed_rows.push_back(row_reg(REG_REPLACE, 32'd1));
        directed_rows.push_back(row_reg(REG_RLEN, 32'd32));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, 8'h41));
        directed_rows.push_back(row_reg(REG_RLEN, 32'd0));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, 8'h61));
        directed_rows.push_back(row_reg(REG_PLEN, 32'd3));
        directed_rows.push_back(row_cmd(CMD_PATTERN, 5'd1, SPACE_BYTE));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, 8'h41));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, NEWLINE_BYTE));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, 8'h43));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, 8'h41));
        directed_rows.push_back(row_cmd(CMD_END, 5'd0, 8'h00));
        directed_rows.push_back(row_reg(REG_PLEN, 32'd32));
        directed_rows.push_back(row_reg(REG_START, 32'hFFFF_FFFF));
        directed_rows.push_back(row_cmd(CMD_TEXT, 5'd0, 8'h41));
        directed_rows.push_back(row_reg(REG_START, 32'd0));
        directed_rows.push_back(row_reg(3'd7, 32'hFFFF_FFFF));
        directed_rows.push_back(row_reg(REG_PLEN, 32'd0));
        directed_rows.push_back(row_cmd(CMD_END, 5'd0, 8'h00));

        s_idle_pct = 25;
        m_idle_pct = 86;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            else
                send_beat(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].res);
        end

        // random phases: sender idles less, then receiver less, then neither
        random_phase(100, 1'b0);
        s_idle_pct = 86;
        m_idle_pct = 25;
        random_phase(100, 1'b0);
        s_idle_pct = 0;
        m_idle_pct = 0;
        random_phase(110, 1'b1);

        s_valid <= 1'b0;
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("stream_find_replace_core: match");
        end else begin
            $display("stream_find_replace_core: mismatch");
        end
        $finish;
    end

endmodule

[stream_find_replace_core.f]
design/sfr_pkg.sv
design/sfr_cell.sv
design/stream_find_replace_core.sv
tb/stream_find_replace_core_tb.sv
